@@ rtl/core/lpg_pkg.sv @@
// Package: shared types and constants of the line point generator.
`default_nettype none
package lpg_pkg;

    localparam int COORD_W    = 16;
    localparam int ABS_W      = 16;
    localparam int DELTA_W    = ABS_W + 1;
    localparam int ERR_W      = 20;
    localparam int CAP_W      = 8;
    localparam int CNT_W      = 6;
    localparam int MAX_POINTS = 63;
    localparam int Q_DEPTH    = 2;
    localparam int Q_AW       = 1;

    localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_back_state;

    // One classified segment, ready for stepping.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic [DELTA_W-1:0]        d_maj;
        logic [DELTA_W-1:0]        d_min;
        logic signed [ERR_W-1:0]   err;
        logic                      x_major;
        logic                      x_pos;
        logic                      x_neg;
        logic                      y_pos;
        logic                      y_neg;
    } t_cmd;

endpackage
`default_nettype wire

@@ rtl/core/lpg_ifs.sv @@
// Interfaces: segment input channel and point output channel.
`default_nettype none
interface lpg_seg_if
    import lpg_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;

    modport source (output valid, output start_x, output start_y, output end_x,
                    output end_y, input ready);
    modport sink   (input valid, input start_x, input start_y, input end_x,
                    input end_y, output ready);
endinterface

interface lpg_pt_if
    import lpg_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;
    logic                      truncated;

    modport source (output valid, output point_x, output point_y, output last_point,
                    output truncated, input ready);
    modport sink   (input valid, input point_x, input point_y, input last_point,
                    input truncated, output ready);
endinterface
`default_nettype wire

@@ rtl/core/lpg_front.sv @@
// Front end: accepts a segment word and classifies it into a stepping command.
`default_nettype none
module lpg_front
    import lpg_pkg::*;
(
    lpg_seg_if.sink              i_seg,
    input  wire logic            i_q_ready,
    output logic                 o_q_valid,
    output t_cmd                 o_q_cmd
);

    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic [ABS_W-1:0]        abs_dx;
    logic [ABS_W-1:0]        abs_dy;
    logic [DELTA_W-1:0]      adx;
    logic [DELTA_W-1:0]      ady;
    logic                    x_major;
    logic [ABS_W-1:0]        half_maj;
    logic [DELTA_W-1:0]      d_min;

    always_comb begin
        dx      = {i_seg.end_x[COORD_W-1], i_seg.end_x}
                - {i_seg.start_x[COORD_W-1], i_seg.start_x};
        dy      = {i_seg.end_y[COORD_W-1], i_seg.end_y}
                - {i_seg.start_y[COORD_W-1], i_seg.start_y};
        abs_dx  = dx[COORD_W] ? ABS_W'(-dx) : ABS_W'(dx);
        abs_dy  = dy[COORD_W] ? ABS_W'(-dy) : ABS_W'(dy);
        adx     = {abs_dx, 1'b0};
        ady     = {abs_dy, 1'b0};
        x_major = (adx >= ady);
        half_maj = x_major ? abs_dx : abs_dy;
        d_min    = x_major ? ady : adx;

        o_q_cmd.x       = i_seg.start_x;
        o_q_cmd.y       = i_seg.start_y;
        o_q_cmd.ex      = i_seg.end_x;
        o_q_cmd.ey      = i_seg.end_y;
        o_q_cmd.d_maj   = x_major ? adx : ady;
        o_q_cmd.d_min   = d_min;
        o_q_cmd.err     = $signed(ERR_W'(d_min)) - $signed(ERR_W'(half_maj));
        o_q_cmd.x_major = x_major;
        o_q_cmd.x_pos   = ~dx[COORD_W] & (dx != '0);
        o_q_cmd.x_neg   = dx[COORD_W];
        o_q_cmd.y_pos   = ~dy[COORD_W] & (dy != '0);
        o_q_cmd.y_neg   = dy[COORD_W];
    end

    assign o_q_valid   = i_seg.valid;
    assign i_seg.ready = i_q_ready;

endmodule
`default_nettype wire

@@ rtl/core/lpg_queue.sv @@
// Command queue: short FIFO between front end and stepping engine.
`default_nettype none
module lpg_queue
    import lpg_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr_valid,
    output logic      o_wr_ready,
    input  t_cmd      i_wr_cmd,
    output logic      o_rd_valid,
    input  wire logic i_rd_ready,
    output t_cmd      o_rd_cmd
);

    t_cmd              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_AW:0]     r_count;
    logic [Q_AW-1:0]   n_wr_ptr;
    logic [Q_AW-1:0]   n_rd_ptr;
    logic [Q_AW:0]     n_count;
    logic              push;
    logic              pop;

    always_comb begin
        o_wr_ready = (r_count != (Q_AW+1)'(Q_DEPTH));
        o_rd_valid = (r_count != '0);
        o_rd_cmd   = r_mem[r_rd_ptr];
        push       = i_wr_valid & o_wr_ready;
        pop        = o_rd_valid & i_rd_ready;
        n_wr_ptr   = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr   = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count    = r_count + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/lpg_back.sv @@
// Back end: steps the line into the output register, one point per cycle unless the receiver stalls.
`default_nettype none
module lpg_back
    import lpg_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [CAP_W-1:0] i_capacity,
    input  wire logic             i_q_valid,
    output logic                  o_q_ready,
    input  t_cmd                  i_q_cmd,
    lpg_pt_if.source              o_pt
);

    t_back_state             r_state, n_state;
    t_cmd                    r_cmd, n_cmd;
    logic [CNT_W-1:0]        r_n, n_n;
    logic                    r_ov, n_ov;
    logic signed [COORD_W-1:0] r_px, n_px;
    logic signed [COORD_W-1:0] r_py, n_py;
    logic                    r_last, n_last;
    logic                    r_trunc, n_trunc;

    logic                    emit;
    logic                    at_end;
    logic [CNT_W:0]          cnt;
    logic [CAP_W:0]          words;
    logic                    done;
    logic                    step_min;
    logic                    maj_pos;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [ERR_W-1:0] err_a;

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_n     = r_n;
        n_ov    = r_ov;
        n_px    = r_px;
        n_py    = r_py;
        n_last  = r_last;
        n_trunc = r_trunc;
        o_q_ready = 1'b0;

        emit   = (r_state == ST_RUN) && (!r_ov || o_pt.ready);
        at_end = (r_cmd.x == r_cmd.ex) && (r_cmd.y == r_cmd.ey);
        cnt    = (CNT_W+1)'(r_n) + 1'b1;
        words  = (CAP_W+1)'({cnt, 1'b0}) + (CAP_W+1)'(2);
        done   = at_end || !(words < (CAP_W+1)'(i_capacity))
              || (cnt == (CNT_W+1)'(MAX_POINTS));

        maj_pos  = r_cmd.x_major ? r_cmd.x_pos : r_cmd.y_pos;
        step_min = (!r_cmd.err[ERR_W-1] && (r_cmd.err != '0))
                || ((r_cmd.err == '0) && maj_pos);
        sx = r_cmd.x_pos ? COORD_W'(1) : (r_cmd.x_neg ? '1 : '0);
        sy = r_cmd.y_pos ? COORD_W'(1) : (r_cmd.y_neg ? '1 : '0);
        err_a = step_min ? r_cmd.err - $signed(ERR_W'(r_cmd.d_maj)) : r_cmd.err;

        if (r_ov && o_pt.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                o_q_ready = 1'b1;
                if (i_q_valid) begin
                    n_cmd   = i_q_cmd;
                    n_n     = '0;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (emit) begin
                    n_ov    = 1'b1;
                    n_px    = r_cmd.x;
                    n_py    = r_cmd.y;
                    n_last  = done;
                    n_trunc = done && !at_end;
                    if (done) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_n       = r_n + 1'b1;
                        n_cmd.err = err_a + $signed(ERR_W'(r_cmd.d_min));
                        if (r_cmd.x_major) begin
                            n_cmd.x = r_cmd.x + sx;
                            if (step_min) begin
                                n_cmd.y = r_cmd.y + sy;
                            end
                        end else begin
                            n_cmd.y = r_cmd.y + sy;
                            if (step_min) begin
                                n_cmd.x = r_cmd.x + sx;
                            end
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_n     <= n_n;
        r_px    <= n_px;
        r_py    <= n_py;
        r_last  <= n_last;
        r_trunc <= n_trunc;
    end

    assign o_pt.valid      = r_ov;
    assign o_pt.point_x    = r_px;
    assign o_pt.point_y    = r_py;
    assign o_pt.last_point = r_last;
    assign o_pt.truncated  = r_trunc;

endmodule
`default_nettype wire

@@ rtl/core/line_point_generator.sv @@
// Top level: Bresenham line point generator.
//
// Usage: a segment word (start_x, start_y, end_x, end_y) enters on i_seg with a
// valid/ready handshake. The block answers on o_pt with one word per grid point of
// the line, start point first; last_point marks the final word of a segment and
// truncated marks a run cut short by the capacity register or the 63-point limit.
// i_cfg_we/i_cfg_data write capacity_words (reset 128); write it only while idle.
// Flow: a taken segment goes through the command queue into the engine's command
// register. While the receiver does not stall, the engine delivers one point per
// cycle and idles after a segment's last point. The front end and a two-entry
// command queue keep taking segments while the engine runs.
// Reset (synchronous, active low) empties the queue, idles the engine and drops
// any pending output word. When the receiver stalls, the output register holds
// its word and the engine waits; the queue fills, then i_seg.ready falls.
`default_nettype none
module line_point_generator
    import lpg_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CAP_W-1:0] i_cfg_data,
    lpg_seg_if.sink               i_seg,
    lpg_pt_if.source              o_pt
);

    logic [CAP_W-1:0] r_capacity;
    logic             fq_valid;
    logic             fq_ready;
    t_cmd             fq_cmd;
    logic             qb_valid;
    logic             qb_ready;
    t_cmd             qb_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_data;
        end
    end

    lpg_front u_front (
        .i_seg     (i_seg),
        .i_q_ready (fq_ready),
        .o_q_valid (fq_valid),
        .o_q_cmd   (fq_cmd)
    );

    lpg_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (fq_valid),
        .o_wr_ready (fq_ready),
        .i_wr_cmd   (fq_cmd),
        .o_rd_valid (qb_valid),
        .i_rd_ready (qb_ready),
        .o_rd_cmd   (qb_cmd)
    );

    lpg_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_capacity (r_capacity),
        .i_q_valid  (qb_valid),
        .o_q_ready  (qb_ready),
        .i_q_cmd    (qb_cmd),
        .o_pt       (o_pt)
    );

endmodule
`default_nettype wire
